@@ hw/rtl/mcs_pkg.sv @@
// Shared types and constants for the motor characterisation sequencer.
package mcs_pkg;

  typedef enum logic [2:0] {
    REG_RAMP_RATE   = 3'd0,
    REG_RAMP_MAX    = 3'd1,
    REG_STEP        = 3'd2,
    REG_TRAVEL      = 3'd3,
    REG_PRE_ROLL    = 3'd4,
    REG_TIME_CAP    = 3'd5,
    REG_PERIOD      = 3'd6,
    REG_SETTLE_TOUT = 3'd7
  } cfg_reg_t;

  localparam int CFG_DATA_W = 31;

  localparam logic [16:0] TIMER_MAX      = 17'h1FFFF;
  localparam int          MS_PER_S       = 1000;
  localparam logic [14:0] RECIP_1000     = 15'd16778;
  localparam int          RECIP_SHIFT    = 24;
  localparam int          SETTLE_MIN_D   = 10;
  localparam int          TRAVEL_RATIO   = 500;
  localparam logic [2:0]  SEGMENT_COUNT  = 3'd4;
  localparam int          RAMP_Q_W       = 22;

  typedef struct packed {
    logic [13:0] ramp_rate_mv_per_s;
    logic [13:0] ramp_max_mv;
    logic [13:0] step_mv;
    logic [30:0] travel_limit;
    logic [15:0] pre_roll_ms;
    logic [15:0] segment_time_cap_ms;
    logic [9:0]  sample_period_ms;
    logic [15:0] settle_timeout_ms;
  } mcs_cfg_t;

  typedef struct packed {
    logic signed [14:0] drive_mv;
    logic               sample_valid;
    logic [16:0]        sample_time_ms;
    logic [1:0]         segment_index;
    logic               segment_last;
    logic               run_busy;
    logic               run_done;
  } mcs_res_t;

endpackage

@@ hw/rtl/mcs_ramp.sv @@
// Running quotient of ramp rate times elapsed drive time divided by 1000.
module mcs_ramp import mcs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                advance,
  input  logic [13:0]         rate,
  output logic [RAMP_Q_W-1:0] quotient
);

  logic [9:0]  rem;
  logic [14:0] sum;
  logic [29:0] prod;
  logic [4:0]  carry;
  logic [14:0] carry_k;

  // The reciprocal is exact for every sum below 17383.
  assign sum     = 15'(rem) + 15'(rate);
  assign prod    = 30'(sum) * 30'(RECIP_1000);
  assign carry   = prod[RECIP_SHIFT +: 5];
  assign carry_k = 15'(carry) * 15'(MS_PER_S);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      quotient <= '0;
      rem      <= '0;
    end else if (advance) begin
      quotient <= quotient + RAMP_Q_W'(carry);
      rem      <= 10'(sum - carry_k);
    end
  end

endmodule

@@ hw/rtl/mcs_core.sv @@
// Sequencer state and the per-transaction result logic.
module mcs_core import mcs_pkg::*; #(
  parameter int POSITION_WIDTH  = 32,
  parameter int SETTLE_CHECK_MS = 100
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mcs_cfg_t                         cfg,
  input  logic                             step,
  input  logic                             mode,
  input  logic signed [POSITION_WIDTH-1:0] position,
  output mcs_res_t                         res,
  output logic signed [POSITION_WIDTH-1:0] sample_position
);

  localparam int PW  = POSITION_WIDTH;
  localparam int CTW = $clog2(SETTLE_CHECK_MS + 1);
  localparam int CW  = (PW + 10 > 32) ? PW + 10 : 32;

  typedef enum logic [1:0] {PH_IDLE, PH_SETTLE, PH_SEGMENT} phase_t;

  phase_t                 phase, phase_next;
  logic [2:0]             segment_count, segment_count_next;
  logic [16:0]            phase_timer, phase_timer_next;
  logic [CTW-1:0]         check_timer, check_timer_next;
  logic [9:0]             sample_timer, sample_timer_next;
  logic signed [PW-1:0]   origin_position, origin_position_next;
  logic signed [PW-1:0]   last_settle_position, last_settle_position_next;
  logic signed [14:0]     drive_level, drive_level_next;

  logic [16:0]            pt_inc;
  logic [CTW-1:0]         ct_inc;
  logic signed [PW-1:0]   origin_eff;
  logic [PW:0]            d_settle, d_segment;
  logic [CW-1:0]          travel_x;
  logic                   settle_stop, seg_stop;
  logic [16:0]            stop_time;
  logic [RAMP_Q_W-1:0]    ramp_q;
  logic [13:0]            mag;
  logic signed [14:0]     seg_drive;
  logic                   ramp_clear, ramp_adv;

  function automatic logic [PW:0] abs_diff(logic signed [PW-1:0] a, logic signed [PW-1:0] b);
    logic signed [PW:0] d;
    d = {a[PW-1], a} - {b[PW-1], b};
    return d[PW] ? (PW+1)'(-d) : (PW+1)'(d);
  endfunction

  mcs_ramp u_ramp (
    .clk      (clk),
    .rst      (rst),
    .clear    (ramp_clear),
    .advance  (ramp_adv),
    .rate     (cfg.ramp_rate_mv_per_s),
    .quotient (ramp_q)
  );

  assign pt_inc     = (phase_timer == TIMER_MAX) ? phase_timer : phase_timer + 17'd1;
  assign ct_inc     = check_timer + CTW'(1);
  assign origin_eff = (phase_timer == '0) ? position : origin_position;
  assign d_settle   = abs_diff(position, last_settle_position);
  assign d_segment  = abs_diff(position, origin_eff);
  assign travel_x   = CW'(cfg.travel_limit);
  assign settle_stop = (CW'(d_settle) < CW'(SETTLE_MIN_D)) ||
                       ((CW'(d_settle) * CW'(TRAVEL_RATIO)) < travel_x);
  assign stop_time  = 17'(cfg.pre_roll_ms) + 17'(cfg.segment_time_cap_ms);
  assign seg_stop   = (phase_timer >= stop_time) ||
                      ((cfg.travel_limit != '0) && (CW'(d_segment) >= travel_x));
  assign mag        = (segment_count < 3'd2) ?
                      ((ramp_q < RAMP_Q_W'(cfg.ramp_max_mv)) ? ramp_q[13:0] : cfg.ramp_max_mv) :
                      cfg.step_mv;
  assign seg_drive  = segment_count[0] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_comb begin
    phase_next                = phase;
    segment_count_next        = segment_count;
    phase_timer_next          = phase_timer;
    check_timer_next          = check_timer;
    sample_timer_next         = sample_timer;
    origin_position_next      = origin_position;
    last_settle_position_next = last_settle_position;
    drive_level_next          = drive_level;
    ramp_clear                = 1'b0;
    ramp_adv                  = 1'b0;
    res                       = '0;
    sample_position           = '0;

    if (mode) begin
      segment_count_next        = '0;
      phase_next                = PH_SETTLE;
      phase_timer_next          = '0;
      check_timer_next          = '0;
      last_settle_position_next = position;
      drive_level_next          = '0;
      res.run_busy              = 1'b1;
    end else begin
      unique case (phase)
        PH_SETTLE: begin
          logic settle_end;
          settle_end   = 1'b0;
          res.run_busy = 1'b1;
          if (cfg.settle_timeout_ms == '0) begin
            settle_end = 1'b1;
          end else begin
            phase_timer_next = pt_inc;
            check_timer_next = ct_inc;
            if (32'(ct_inc) >= 32'(SETTLE_CHECK_MS)) begin
              check_timer_next = '0;
              if (settle_stop) begin
                settle_end = 1'b1;
              end else begin
                last_settle_position_next = position;
                if (pt_inc >= 17'(cfg.settle_timeout_ms)) settle_end = 1'b1;
              end
            end
          end
          if (settle_end) begin
            if (segment_count >= SEGMENT_COUNT) begin
              phase_next   = PH_IDLE;
              res.run_done = 1'b1;
            end else begin
              phase_next        = PH_SEGMENT;
              phase_timer_next  = '0;
              sample_timer_next = '0;
              drive_level_next  = '0;
              ramp_clear        = 1'b1;
            end
          end
        end
        PH_SEGMENT: begin
          res.run_busy         = 1'b1;
          res.segment_index    = segment_count[1:0];
          origin_position_next = origin_eff;
          if (sample_timer == '0) begin
            if (seg_stop) begin
              res.segment_last          = 1'b1;
              segment_count_next        = segment_count + 3'd1;
              phase_next                = PH_SETTLE;
              phase_timer_next          = '0;
              check_timer_next          = '0;
              last_settle_position_next = position;
              drive_level_next          = '0;
            end else begin
              drive_level_next   = (phase_timer < 17'(cfg.pre_roll_ms)) ? 15'sd0 : seg_drive;
              res.sample_valid   = 1'b1;
              res.sample_time_ms = phase_timer;
              sample_position    = position;
              sample_timer_next  = (cfg.sample_period_ms == '0) ? '0 :
                                   cfg.sample_period_ms - 10'd1;
            end
          end else begin
            sample_timer_next = sample_timer - 10'd1;
          end
          if (!res.segment_last) begin
            phase_timer_next = pt_inc;
            ramp_adv = (phase_timer != TIMER_MAX) &&
                       (phase_timer >= 17'(cfg.pre_roll_ms));
          end
        end
        default: begin
        end
      endcase
    end
    res.drive_mv = drive_level_next;
    ramp_clear   = ramp_clear & step;
    ramp_adv     = ramp_adv & step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      segment_count        <= '0;
      phase_timer          <= '0;
      check_timer          <= '0;
      sample_timer         <= '0;
      origin_position      <= '0;
      last_settle_position <= '0;
      drive_level          <= '0;
    end else if (step) begin
      phase                <= phase_next;
      segment_count        <= segment_count_next;
      phase_timer          <= phase_timer_next;
      check_timer          <= check_timer_next;
      sample_timer         <= sample_timer_next;
      origin_position      <= origin_position_next;
      last_settle_position <= last_settle_position_next;
      drive_level          <= drive_level_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.run_done |=> phase == PH_IDLE)
    else $error("run completed but sequencer not idle");

  a_drive_only_in_segment: assert property (@(posedge clk) disable iff (rst)
    phase != PH_SEGMENT |-> drive_level == '0)
    else $error("drive applied outside a segment");

  a_last_no_sample: assert property (@(posedge clk) disable iff (rst)
    step && res.segment_last |-> !res.sample_valid && res.drive_mv == '0)
    else $error("segment end carries a sample or drive");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    segment_count <= SEGMENT_COUNT)
    else $error("segment count out of range");

endmodule

@@ hw/rtl/motor_characterization_sequencer.sv @@
// Top level: configuration registers, input register and result register.
//
//  Channel   Direction  Transaction contents
//  s_*       in         tuser: mode; tdata: position
//  m_*       out        tuser: sample_valid; tlast: segment_last; tdata: result fields
//  cfg_*     in         register write, index and data
//
// Each transaction is one step; one may be accepted every cycle unless m_* stalls.
// Each result is registered when its input leaves the input register.
// The input register is released whenever the result register is empty or being taken.
// Reset returns the sequencer to idle and loads the register defaults.
module motor_characterization_sequencer import mcs_pkg::*; #(
  parameter int POSITION_WIDTH  = 32,
  parameter int SETTLE_CHECK_MS = 100,
  localparam int IN_W  = ((POSITION_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((POSITION_WIDTH + 36 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // position
  input  logic                  s_tuser,   // mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // drive_mv, sample_time_ms, sample_position,
                                           // segment_index, run_busy, run_done
  output logic                  m_tuser,   // sample_valid
  output logic                  m_tlast,
  input  logic                  cfg_wen,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW = POSITION_WIDTH;

  mcs_cfg_t             cfg;
  logic                 in_valid;
  logic                 in_mode;
  logic signed [PW-1:0] in_pos;
  logic                 advance;
  mcs_res_t             res;
  logic signed [PW-1:0] res_pos;
  mcs_res_t             out_res;
  logic signed [PW-1:0] out_pos;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_rate_mv_per_s  <= 14'd250;
      cfg.ramp_max_mv         <= 14'd6000;
      cfg.step_mv             <= 14'd6000;
      cfg.travel_limit        <= '0;
      cfg.pre_roll_ms         <= 16'd500;
      cfg.segment_time_cap_ms <= 16'd10000;
      cfg.sample_period_ms    <= 10'd10;
      cfg.settle_timeout_ms   <= 16'd2000;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_RAMP_RATE:   cfg.ramp_rate_mv_per_s  <= cfg_data[13:0];
        REG_RAMP_MAX:    cfg.ramp_max_mv         <= cfg_data[13:0];
        REG_STEP:        cfg.step_mv             <= cfg_data[13:0];
        REG_TRAVEL:      cfg.travel_limit        <= cfg_data[30:0];
        REG_PRE_ROLL:    cfg.pre_roll_ms         <= cfg_data[15:0];
        REG_TIME_CAP:    cfg.segment_time_cap_ms <= cfg_data[15:0];
        REG_PERIOD:      cfg.sample_period_ms    <= cfg_data[9:0];
        REG_SETTLE_TOUT: cfg.settle_timeout_ms   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_pos  <= $signed(s_tdata[PW-1:0]);
    end
  end

  mcs_core #(
    .POSITION_WIDTH  (POSITION_WIDTH),
    .SETTLE_CHECK_MS (SETTLE_CHECK_MS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .step            (advance),
    .mode            (in_mode),
    .position        (in_pos),
    .res             (res),
    .sample_position (res_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
      out_pos <= res_pos;
    end
  end

  assign m_tdata = OUT_W'({out_res.run_done, out_res.run_busy, out_res.segment_index,
                           out_pos, out_res.sample_time_ms, out_res.drive_mv});
  assign m_tuser = out_res.sample_valid;
  assign m_tlast = out_res.segment_last;

endmodule

@@ tb/sequence_tracker_pkg.sv @@
// Scoreboard class that predicts and checks the sequencer's per-tick reports.
package sequence_tracker_pkg;
  import mcs_pkg::*;

  localparam int SETTLE_CHECK_INTERVAL = 100;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SETTLE,
    SEQ_SEGMENT
  } seq_state_t;

  // Same layout as the result tdata bus, highest bits first.
  typedef struct packed {
    logic [3:0]  pad;
    logic        run_done;
    logic        run_busy;
    logic [1:0]  segment_index;
    logic [31:0] sample_position;
    logic [16:0] sample_time_ms;
    logic [14:0] drive_mv;
  } report_data_t;

  typedef struct {
    report_data_t data;
    logic         sample_valid;
    logic         segment_last;
  } tick_report_t;

  class sequence_tracker;
    mcs_cfg_t     regs;
    seq_state_t   state;
    logic [2:0]   segments_done;
    int unsigned  phase_ms;
    int unsigned  check_ms;
    int unsigned  sample_wait;
    longint       origin_pos;
    longint       settle_ref_pos;
    longint       drive_level;
    tick_report_t predicted_reports[$];
    int           mismatches;
    int           reports_seen;

    function new();
      regs.ramp_rate_mv_per_s  = 14'd250;
      regs.ramp_max_mv         = 14'd6000;
      regs.step_mv             = 14'd6000;
      regs.travel_limit        = 31'd0;
      regs.pre_roll_ms         = 16'd500;
      regs.segment_time_cap_ms = 16'd10000;
      regs.sample_period_ms    = 10'd10;
      regs.settle_timeout_ms   = 16'd2000;
      state          = SEQ_IDLE;
      segments_done  = '0;
      phase_ms       = 0;
      check_ms       = 0;
      sample_wait    = 0;
      origin_pos     = 0;
      settle_ref_pos = 0;
      drive_level    = 0;
      mismatches     = 0;
      reports_seen   = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_RAMP_RATE:   regs.ramp_rate_mv_per_s  = value[13:0];
        REG_RAMP_MAX:    regs.ramp_max_mv         = value[13:0];
        REG_STEP:        regs.step_mv             = value[13:0];
        REG_TRAVEL:      regs.travel_limit        = value[30:0];
        REG_PRE_ROLL:    regs.pre_roll_ms         = value[15:0];
        REG_TIME_CAP:    regs.segment_time_cap_ms = value[15:0];
        REG_PERIOD:      regs.sample_period_ms    = value[9:0];
        REG_SETTLE_TOUT: regs.settle_timeout_ms   = value[15:0];
        default: ;
      endcase
    endfunction

    function void enter_settle(longint pos);
      state          = SEQ_SETTLE;
      phase_ms       = 0;
      check_ms       = 0;
      settle_ref_pos = pos;
      drive_level    = 0;
    endfunction

    function bit busy();
      return state != SEQ_IDLE;
    endfunction

    function bit in_segment();
      return state == SEQ_SEGMENT;
    endfunction

    function int pending();
      return predicted_reports.size();
    endfunction

    function void note_input(logic start, logic signed [31:0] position);
      tick_report_t r;
      longint       pos;
      longint       span;
      longint       mag;
      logic         finished;
      logic         stop;
      int unsigned  elapsed;
      r.data         = '0;
      r.sample_valid = 1'b0;
      r.segment_last = 1'b0;
      pos = position;
      if (start) begin
        segments_done = '0;
        enter_settle(pos);
        r.data.run_busy = 1'b1;
      end else if (state == SEQ_SETTLE) begin
        r.data.run_busy = 1'b1;
        finished = 1'b0;
        if (regs.settle_timeout_ms == 0) begin
          finished = 1'b1;
        end else begin
          if (phase_ms < TIMER_MAX) phase_ms++;
          check_ms++;
          if (check_ms >= SETTLE_CHECK_INTERVAL) begin
            span = pos - settle_ref_pos;
            if (span < 0) span = -span;
            check_ms = 0;
            if (span < SETTLE_MIN_D || TRAVEL_RATIO * span < longint'(regs.travel_limit)) begin
              finished = 1'b1;
            end else begin
              settle_ref_pos = pos;
              if (phase_ms >= regs.settle_timeout_ms) finished = 1'b1;
            end
          end
        end
        if (finished) begin
          if (segments_done >= SEGMENT_COUNT) begin
            state = SEQ_IDLE;
            r.data.run_done = 1'b1;
          end else begin
            state       = SEQ_SEGMENT;
            phase_ms    = 0;
            sample_wait = 0;
            drive_level = 0;
          end
        end
      end else if (state == SEQ_SEGMENT) begin
        elapsed = phase_ms;
        r.data.run_busy = 1'b1;
        r.data.segment_index = segments_done[1:0];
        if (elapsed == 0) origin_pos = pos;
        if (sample_wait == 0) begin
          span = pos - origin_pos;
          if (span < 0) span = -span;
          stop = elapsed >= regs.pre_roll_ms + regs.segment_time_cap_ms;
          if (regs.travel_limit != 0 && span >= longint'(regs.travel_limit)) stop = 1'b1;
          if (stop) begin
            r.segment_last = 1'b1;
            segments_done++;
            enter_settle(pos);
          end else begin
            if (elapsed < regs.pre_roll_ms) begin
              drive_level = 0;
            end else begin
              if (segments_done < 2) begin
                mag = longint'(regs.ramp_rate_mv_per_s) *
                      longint'(elapsed - regs.pre_roll_ms) / MS_PER_S;
                if (mag > longint'(regs.ramp_max_mv)) mag = regs.ramp_max_mv;
              end else begin
                mag = regs.step_mv;
              end
              drive_level = segments_done[0] ? -mag : mag;
            end
            r.sample_valid = 1'b1;
            r.data.sample_time_ms = elapsed[16:0];
            r.data.sample_position = position;
            sample_wait = (regs.sample_period_ms == 0) ? 0 : regs.sample_period_ms - 1;
          end
        end else begin
          sample_wait--;
        end
        if (!r.segment_last && phase_ms < TIMER_MAX) phase_ms++;
      end
      r.data.drive_mv = drive_level[14:0];
      predicted_reports.insert(predicted_reports.size(), r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report %0d: %s mismatch, expected %0h, got %0h",
                   reports_seen, field, want, got);
      end
    endfunction

    function void check_report(logic tuser, logic tlast, logic [71:0] tdata);
      tick_report_t want;
      report_data_t got;
      reports_seen++;
      if (predicted_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report %0d: unexpected transaction, tdata %h tuser %b tlast %b",
                   reports_seen, tdata, tuser, tlast);
        return;
      end
      want = predicted_reports.pop_front();
      got  = tdata;
      compare("drive_mv", want.data.drive_mv, got.drive_mv);
      compare("sample_valid", want.sample_valid, tuser);
      compare("sample_time_ms", want.data.sample_time_ms, got.sample_time_ms);
      compare("sample_position", want.data.sample_position, got.sample_position);
      compare("segment_index", want.data.segment_index, got.segment_index);
      compare("segment_last", want.segment_last, tlast);
      compare("run_busy", want.data.run_busy, got.run_busy);
      compare("run_done", want.data.run_done, got.run_done);
      compare("tdata padding", want.data.pad, got.pad);
    endfunction
  endclass

endpackage

@@ tb/tb.sv @@
// Top-level testbench for the motor characterisation sequencer.
module tb;
  import mcs_pkg::*;
  import sequence_tracker_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 500;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [71:0]           m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_wen   = 1'b0;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  sequence_tracker tracker = new();

  bit          tx_quiet     = 1'b0;
  bit          rx_quiet     = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned cycle_count  = 0;
  int          stimulus_items = 0;

  motor_characterization_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("motor_characterization_sequencer regression: fail");
      $finish;
    end
  end

  task automatic send_item(logic mode, logic [31:0] position);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= position;
    do @(posedge clk); while (!s_tready);
    tracker.note_input(mode, position);
  endtask

  task automatic set_reg(cfg_reg_t idx, int unsigned value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    tracker.write_reg(idx, value[CFG_DATA_W-1:0]);
  endtask

  task automatic load_settings(int unsigned rate, int unsigned ramp_max, int unsigned step,
                               int unsigned travel, int unsigned pre_roll,
                               int unsigned time_cap, int unsigned period,
                               int unsigned timeout);
    set_reg(REG_RAMP_RATE, rate);
    set_reg(REG_RAMP_MAX, ramp_max);
    set_reg(REG_STEP, step);
    set_reg(REG_TRAVEL, travel);
    set_reg(REG_PRE_ROLL, pre_roll);
    set_reg(REG_TIME_CAP, time_cap);
    set_reg(REG_PERIOD, period);
    set_reg(REG_SETTLE_TOUT, timeout);
    cfg_wen <= 1'b0;
  endtask

  task automatic wait_for_reports();
    s_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_sequence(int tick_limit);
    logic signed [31:0] pos;
    int                 n;
    int                 restart_at;
    bit                 noisy;
    bit                 restless;
    pos        = $urandom;
    noisy      = ($urandom_range(0, 7) == 0);
    restless   = ($urandom_range(0, 2) == 0);
    restart_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, tick_limit - 1)) : -1;
    send_item(1'b1, pos);
    stimulus_items++;
    n = 0;
    while (tracker.busy() && n < tick_limit) begin
      if (n == restart_at) begin
        send_item(1'b1, pos);
      end else begin
        if (noisy)
          pos = $urandom;
        else if (tracker.in_segment())
          pos = pos + $urandom_range(0, 50);
        else if (restless && $urandom_range(0, 3) == 0)
          pos = pos + $urandom_range(0, 400) - 32'd200;
        else
          pos = pos + $urandom_range(0, 8) - 32'd4;
        send_item(1'b0, pos);
      end
      n++;
      stimulus_items++;
    end
    repeat ($urandom_range(0, 3)) send_item(1'b0, $urandom);
  endtask

  // The receiver draws a stall before every transaction, or holds off at length on request.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.check_report(m_tuser, m_tlast, m_tdata);
    end
  end

  initial begin
    logic signed [31:0] ramp_walk [12] = '{1000, 1000, 1000, 1010, 1020, 1030,
                                           1040, 1040, 1040, 1100, 1100, 1100};
    bit          settle_checks;
    int unsigned travel;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Idle ticks at the position extremes must report all zeros.
    send_item(1'b0, 32'h0000_0000);
    send_item(1'b0, 32'h7FFF_FFFF);
    send_item(1'b0, 32'h8000_0000);
    send_item(1'b0, 32'hFFFF_FFFF);
    wait_for_reports();

    // Short segments: a ramp ended by the time cap, a travel-limit stop, a step, then a restart mid-run.
    load_settings(12000, 100, 12000, 50, 1, 3, 0, 0);
    foreach (ramp_walk[i]) send_item(i == 0, ramp_walk[i]);
    send_item(1'b1, -32'sd5);
    wait_for_reports();

    // Everything at zero: each segment ends on its first tick.
    load_settings(0, 0, 0, 0, 0, 0, 0, 0);
    send_item(1'b1, 32'h8000_0000);
    repeat (10) send_item(1'b0, $urandom);

    for (int phase_no = 0; stimulus_items < RANDOM_ITEMS; phase_no++) begin
      wait_for_reports();
      settle_checks = (phase_no == 1) || ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: travel = 0;
        1: travel = $urandom_range(1, 300);
        2: travel = $urandom_range(300, 5000);
        default: travel = $urandom & 32'h7FFF_FFFF;
      endcase
      if (phase_no == 0)
        load_settings(12000, 12000, 12000, 32'h7FFF_FFFF, 65535, 65535, 1000, 65535);
      else
        load_settings($urandom_range(0, 12000), $urandom_range(0, 12000),
                      $urandom_range(0, 12000), travel, $urandom_range(0, 6),
                      $urandom_range(0, 40), $urandom_range(0, 6),
                      settle_checks ? $urandom_range(1, 350) : 0);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) begin
        tx_quiet = 1'b1;
        hold_request = 1'b1;
      end
      repeat ((phase_no < 3) ? 1 : $urandom_range(1, 2))
        run_sequence((phase_no == 0) ? 150 : (settle_checks ? 220 : 120));
    end

    wait_for_reports();
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("motor_characterization_sequencer regression: pass");
    else
      $display("motor_characterization_sequencer regression: fail");
    $finish;
  end

endmodule
